@@ hdl/sliding_median_filter_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding median filter
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SMF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding median filter check failed");

// Next-cycle implication
`define SMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding median filter check failed");

`else

`define SMF_ASSERT_IMPL(lbl, ante, cons)
`define SMF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding median filter package
// Shared widths, sample and status codes, element type and FSM states.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int WINDOW_DEF = 9;

    localparam logic [SAMPLE_W-1:0] SAMPLE_READ_ERROR   = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_OUT_OF_RANGE = 16'h0000;

    localparam logic [STATUS_W-1:0] STATUS_VALID        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_READ_ERROR   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

    // One entry of the sorted chain
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] value;
    } t_elem;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

@@ hdl/smf_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted-chain cell
// Holds one window sample and its age. On an update it drops the evicted
// entry, makes room for the new sample and takes its value from itself, its
// lower neighbor, its upper neighbor or the new sample.
// ----------------------------------------------------------------------------
module smf_cell
    import smf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int AGE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [SAMPLE_W-1:0] i_x,
    input  t_elem            i_up,
    input  logic [AGE_W-1:0] i_up_age,
    input  logic             i_evict_below,
    input  t_elem            i_prev_a,
    input  logic [AGE_W-1:0] i_prev_a_age,
    input  logic             i_prev_gt,
    output t_elem            o_elem,
    output logic [AGE_W-1:0] o_age,
    output logic             o_evict_below,
    output t_elem            o_a,
    output logic [AGE_W-1:0] o_a_age,
    output logic             o_gt
);

    localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW - 1);

    t_elem            r_elem, n_elem;
    logic [AGE_W-1:0] r_age,  n_age;
    logic             w_evict;
    logic             w_shift;
    t_elem            w_a;
    logic [AGE_W-1:0] w_a_age;
    logic             w_gt;

    always_comb begin
        w_evict = r_elem.valid && (r_age == AGE_LAST);
        w_shift = i_evict_below || w_evict;
        // Close the gap left by the evicted entry
        w_a     = w_shift ? i_up     : r_elem;
        w_a_age = w_shift ? i_up_age : r_age;
        // Empty entries sort above every sample
        w_gt    = !w_a.valid || (w_a.value > i_x);

        if (i_prev_gt) begin
            n_elem = i_prev_a;
            n_age  = i_prev_a_age + AGE_W'(1);
        end else if (w_gt) begin
            n_elem.valid = 1'b1;
            n_elem.value = i_x;
            n_age        = '0;
        end else begin
            n_elem = w_a;
            n_age  = w_a_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem.valid <= 1'b0;
        end else if (i_load) begin
            r_elem.valid <= n_elem.valid;
        end
        if (i_load) begin
            r_elem.value <= n_elem.value;
            r_age        <= n_age;
        end
    end

    assign o_elem        = r_elem;
    assign o_age         = r_age;
    assign o_evict_below = w_shift;
    assign o_a           = w_a;
    assign o_a_age       = w_a_age;
    assign o_gt          = w_gt;

endmodule

@@ hdl/smf_chain.sv @@
// ----------------------------------------------------------------------------
// Sorted sample chain
// A row of WINDOW cells kept in ascending order; valid entries fill the low
// end. One update inserts a sample and evicts the oldest when full.
// ----------------------------------------------------------------------------
module smf_chain
    import smf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [SAMPLE_W-1:0]            i_x,
    output logic [WINDOW-1:0][SAMPLE_W-1:0] o_values,
    output logic [WINDOW-1:0]              o_valids
);

    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam t_elem ELEM_EMPTY = '{valid: 1'b0, value: '0};

    t_elem            w_elem  [WINDOW];
    logic [AGE_W-1:0] w_age   [WINDOW];
    logic             w_evb   [WINDOW];
    t_elem            w_a     [WINDOW];
    logic [AGE_W-1:0] w_a_age [WINDOW];
    logic             w_gt    [WINDOW];

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        t_elem            w_up;
        logic [AGE_W-1:0] w_up_age;
        logic             w_evb_in;
        t_elem            w_prev_a;
        logic [AGE_W-1:0] w_prev_age;
        logic             w_prev_gt;

        if (g == WINDOW - 1) begin : g_top
            assign w_up     = ELEM_EMPTY;
            assign w_up_age = '0;
        end else begin : g_mid
            assign w_up     = w_elem[g+1];
            assign w_up_age = w_age[g+1];
        end

        if (g == 0) begin : g_bottom
            assign w_evb_in   = 1'b0;
            assign w_prev_a   = ELEM_EMPTY;
            assign w_prev_age = '0;
            assign w_prev_gt  = 1'b0;
        end else begin : g_link
            assign w_evb_in   = w_evb[g-1];
            assign w_prev_a   = w_a[g-1];
            assign w_prev_age = w_a_age[g-1];
            assign w_prev_gt  = w_gt[g-1];
        end

        smf_cell #(
            .WINDOW (WINDOW),
            .AGE_W  (AGE_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (i_load),
            .i_x           (i_x),
            .i_up          (w_up),
            .i_up_age      (w_up_age),
            .i_evict_below (w_evb_in),
            .i_prev_a      (w_prev_a),
            .i_prev_a_age  (w_prev_age),
            .i_prev_gt     (w_prev_gt),
            .o_elem        (w_elem[g]),
            .o_age         (w_age[g]),
            .o_evict_below (w_evb[g]),
            .o_a           (w_a[g]),
            .o_a_age       (w_a_age[g]),
            .o_gt          (w_gt[g])
        );

        assign o_values[g] = w_elem[g].value;
        assign o_valids[g] = w_elem[g].valid;
    end

endmodule

@@ hdl/sliding_median_filter.sv @@
// ----------------------------------------------------------------------------
// Sliding median filter
// Median of the most recent WINDOW valid distance samples.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready / i_sample): one distance sample per
// transaction. 16'hFFFF reports a read error, zero reports out of range;
// neither enters the window. Any other sample is inserted into a sorted
// chain of cells and, once the chain is full, the oldest sample leaves.
// Output channel (o_valid / i_ready): one transaction per input with
// o_status, o_median (upper median of the window, zero unless status is
// valid) and o_raw_echo (the sample unchanged).
// The chain updates at the edge that accepts the sample; the result is
// loaded into the output register from ST_EMIT once it is free, and
// the median tap is read there, after the chain update. Input is taken
// only in ST_IDLE, so no new sample is accepted while one is in ST_EMIT.
// A new sample is accepted while a finished result waits in the output
// register; once a second result is ready, input stalls until the
// receiver takes the first. Reset empties the window and the output.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_macros.svh"

module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SAMPLE_W-1:0] o_median,
    output logic [SAMPLE_W-1:0] o_raw_echo
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] r_stat;
    logic [SAMPLE_W-1:0] r_raw;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SAMPLE_W-1:0] r_out_median;
    logic [SAMPLE_W-1:0] r_out_raw;

    logic                w_accept;
    logic [STATUS_W-1:0] w_stat;
    logic                w_load;
    logic                w_count_up;
    logic                w_emit;
    logic [IDX_W-1:0]    w_mid_idx;
    logic [WINDOW-1:0][SAMPLE_W-1:0] w_values;
    logic [WINDOW-1:0]   w_valids;

    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (i_sample == SAMPLE_READ_ERROR) begin
            w_stat = STATUS_READ_ERROR;
        end else if (i_sample == SAMPLE_OUT_OF_RANGE) begin
            w_stat = STATUS_OUT_OF_RANGE;
        end else begin
            w_stat = STATUS_VALID;
        end
    end

    assign w_load     = w_accept && (w_stat == STATUS_VALID);
    assign w_count_up = w_load && (r_count != CNT_FULL);

    smf_chain #(
        .WINDOW (WINDOW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_x      (i_sample),
        .o_values (w_values),
        .o_valids (w_valids)
    );

    assign w_mid_idx = IDX_W'(r_count >> 1);

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register frees up
                if (!r_out_valid || i_ready) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = w_emit || (r_out_valid && !i_ready);
        n_count     = r_count;
        if (w_count_up) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stat <= w_stat;
            r_raw  <= i_sample;
        end
        if (w_emit) begin
            r_out_status <= r_stat;
            r_out_raw    <= r_raw;
            r_out_median <= (r_stat == STATUS_VALID) ? w_values[w_mid_idx] : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_median   = r_out_median;
    assign o_raw_echo = r_out_raw;

    `SMF_ASSERT_IMPL(a_median_zero, o_valid && (o_status != STATUS_VALID), o_median == '0)
    `SMF_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_FULL)
    `SMF_ASSERT_IMPL(a_count_cells, 1'b1, $countones(w_valids) == int'(r_count))
    `SMF_ASSERT_NEXT(a_count_step, w_count_up, r_count == $past(r_count) + CNT_W'(1))

endmodule
